// ===== hw/rtl/dlps_pkg.sv =====
package dlps_pkg;

	// Fixed-point formats
	localparam int COORD_FRAC_BITS = 8;
	localparam int STEP_FRAC_BITS  = 16;
	localparam int COORD_W         = 24;
	localparam int MAG_W           = COORD_W + 1;
	localparam int POS_W           = 40;
	localparam int QUO_W           = STEP_FRAC_BITS + 1;
	localparam int STEP_W          = STEP_FRAC_BITS + 2;
	localparam int PTS_W           = MAG_W - COORD_FRAC_BITS + 1;
	localparam int POS_UP          = (STEP_FRAC_BITS >= COORD_FRAC_BITS) ?
	                                 (STEP_FRAC_BITS - COORD_FRAC_BITS) : 0;
	localparam int POS_DN          = (STEP_FRAC_BITS < COORD_FRAC_BITS) ?
	                                 (COORD_FRAC_BITS - STEP_FRAC_BITS) : 0;

	// Field widths
	localparam int DIM_W      = 15;
	localparam int RND_W      = DIM_W + 1;
	localparam int LB_W       = 16;
	localparam int PB_W       = 4;
	localparam int COLOR_W    = 32;
	localparam int OFF_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Queue and divider sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int DIV_CNT_W   = $clog2(QUO_W);

	// Item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = CFG_IDX_W'(5);

	// Register reset values
	localparam logic [DIM_W-1:0] RST_MAP_WIDTH    = DIM_W'(1024);
	localparam logic [DIM_W-1:0] RST_MAP_HEIGHT   = DIM_W'(768);
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(1024);
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(768);
	localparam logic [LB_W-1:0]  RST_LINE_BYTES   = LB_W'(4096);
	localparam logic [PB_W-1:0]  RST_PIXEL_BYTES  = PB_W'(4);

	typedef struct packed {
		logic                       mode;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0]         color;
	} dlps_in_t;

	typedef struct packed {
		logic [DIM_W-1:0]   pixel_x;
		logic [DIM_W-1:0]   pixel_y;
		logic [OFF_W-1:0]   byte_offset;
		logic [COLOR_W-1:0] pixel_color;
		logic               visible;
		logic               last_point;
	} dlps_out_t;

	typedef struct packed {
		logic [DIM_W-1:0] map_width;
		logic [DIM_W-1:0] map_height;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [LB_W-1:0]  line_bytes;
		logic [PB_W-1:0]  pixel_bytes;
	} dlps_cfg_t;

	// Classified item as it waits in the queue
	typedef struct packed {
		logic                     is_step;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [MAG_W-1:0]         mag_x;
		logic [MAG_W-1:0]         mag_y;
		logic                     neg_x;
		logic                     neg_y;
		logic [COLOR_W-1:0]       color;
	} dlps_cmd_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] num_x;
		logic [MAG_W-1:0] num_y;
		logic [MAG_W-1:0] den;
	} dlps_div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] q_x;
		logic [QUO_W-1:0] q_y;
	} dlps_div_res_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} dlps_state_t;

	// Coordinate to position format; a right shift here is a floor
	function automatic logic signed [POS_W-1:0] to_pos(input logic signed [COORD_W-1:0] c);
		logic signed [POS_W-1:0] ext;
		ext = {{(POS_W-COORD_W){c[COORD_W-1]}}, c};
		return (ext <<< POS_UP) >>> POS_DN;
	endfunction

endpackage

// ===== hw/rtl/dda_line_pixel_stepper_unit.sv =====
// Channel  Direction  Handshake                 Payload
// item     in         item_valid / item_stall   dlps_in_t (load or step)
// point    out        point_valid / point_stall dlps_out_t
// cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Step beats: one point per cycle sustained while no load is dividing and point_stall is low;
// each passes the queue, stage 1 and the output register. Load beats: setup, 17 radix-2
// divider steps for x and y side by side, increment latch; steps behind a load wait in the queue.
// Reset: registers return to their defaults and no line is active; no clearing pass.
// Stalls: point_stall holds the output register; item_stall rises when the 4-entry
// queue is full. cfg_ready is always high.
module dda_line_pixel_stepper_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  dlps_pkg::dlps_in_t                  item,
	output logic                                point_valid,
	input  logic                                point_stall,
	output dlps_pkg::dlps_out_t                 point,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dlps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	dlps_pkg::dlps_cfg_t     cfg_q;
	dlps_pkg::dlps_cmd_t     q_data;
	dlps_pkg::dlps_cmd_t     q_head;
	dlps_pkg::dlps_div_req_t div_req;
	dlps_pkg::dlps_div_res_t div_res;
	logic                    q_push;
	logic                    q_pop;
	logic                    q_full;
	logic                    q_empty;

	assign cfg_ready = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width    <= dlps_pkg::RST_MAP_WIDTH;
			cfg_q.map_height   <= dlps_pkg::RST_MAP_HEIGHT;
			cfg_q.image_width  <= dlps_pkg::RST_IMAGE_WIDTH;
			cfg_q.image_height <= dlps_pkg::RST_IMAGE_HEIGHT;
			cfg_q.line_bytes   <= dlps_pkg::RST_LINE_BYTES;
			cfg_q.pixel_bytes  <= dlps_pkg::RST_PIXEL_BYTES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dlps_pkg::CFG_MAP_WIDTH:    cfg_q.map_width    <= cfg_data[dlps_pkg::DIM_W-1:0];
				dlps_pkg::CFG_MAP_HEIGHT:   cfg_q.map_height   <= cfg_data[dlps_pkg::DIM_W-1:0];
				dlps_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[dlps_pkg::DIM_W-1:0];
				dlps_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[dlps_pkg::DIM_W-1:0];
				dlps_pkg::CFG_LINE_BYTES:   cfg_q.line_bytes   <= cfg_data[dlps_pkg::LB_W-1:0];
				dlps_pkg::CFG_PIXEL_BYTES:  cfg_q.pixel_bytes  <= cfg_data[dlps_pkg::PB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dlps_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	dlps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	dlps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	dlps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.div_req     (div_req),
		.div_res     (div_res),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point)
	);

	// Queue never overflows or underflows
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("queue pop while empty");

	// A load leaves the sequencer idle state, so starts never come back to back
	a_div_start_single: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_req.start)
		else $error("divider started twice in a row");

	// Divider finishes only while no new division is being started
	a_div_done_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> !div_req.start)
		else $error("divider start during finish");

endmodule

// ===== hw/rtl/dlps_front.sv =====
module dlps_front (
	input  logic                item_valid,
	output logic                item_stall,
	input  dlps_pkg::dlps_in_t  item,
	input  logic                q_full,
	output logic                q_push,
	output dlps_pkg::dlps_cmd_t q_data
);

	logic signed [dlps_pkg::MAG_W-1:0] dx;
	logic signed [dlps_pkg::MAG_W-1:0] dy;

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	// Deltas and their magnitudes; the back end only needs max and divide
	always_comb begin
		dx = {item.end_x[dlps_pkg::COORD_W-1], item.end_x}
		   - {item.start_x[dlps_pkg::COORD_W-1], item.start_x};
		dy = {item.end_y[dlps_pkg::COORD_W-1], item.end_y}
		   - {item.start_y[dlps_pkg::COORD_W-1], item.start_y};

		q_data.is_step = (item.mode == dlps_pkg::MODE_STEP);
		q_data.pos_x   = dlps_pkg::to_pos(item.start_x);
		q_data.pos_y   = dlps_pkg::to_pos(item.start_y);
		q_data.neg_x   = dx[dlps_pkg::MAG_W-1];
		q_data.neg_y   = dy[dlps_pkg::MAG_W-1];
		q_data.mag_x   = dx[dlps_pkg::MAG_W-1] ? (~dx + 1'b1) : dx;
		q_data.mag_y   = dy[dlps_pkg::MAG_W-1] ? (~dy + 1'b1) : dy;
		q_data.color   = item.color;
	end

endmodule

// ===== hw/rtl/dlps_queue.sv =====
module dlps_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dlps_pkg::dlps_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output dlps_pkg::dlps_cmd_t head,
	output logic                empty
);

	dlps_pkg::dlps_cmd_t            slots_q [dlps_pkg::QUEUE_DEPTH];
	logic [dlps_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [dlps_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [dlps_pkg::QPTR_W:0]      count_q;

	assign full  = (count_q == (dlps_pkg::QPTR_W+1)'(dlps_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	function automatic logic [dlps_pkg::QPTR_W-1:0] next_ptr(
		input logic [dlps_pkg::QPTR_W-1:0] p);
		if (p == dlps_pkg::QPTR_W'(dlps_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/dlps_div.sv =====
module dlps_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dlps_pkg::dlps_div_req_t req,
	output dlps_pkg::dlps_div_res_t res
);

	logic                           busy_q;
	logic                           done_q;
	logic [dlps_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [dlps_pkg::MAG_W-1:0]     den_q;
	logic                           den_zero_q;
	logic [dlps_pkg::MAG_W-1:0]     rx_q;
	logic [dlps_pkg::MAG_W-1:0]     ry_q;
	logic [dlps_pkg::QUO_W-1:0]     qx_q;
	logic [dlps_pkg::QUO_W-1:0]     qy_q;

	logic [dlps_pkg::MAG_W:0]       tx;
	logic [dlps_pkg::MAG_W:0]       ty;
	logic [dlps_pkg::MAG_W:0]       nx;
	logic [dlps_pkg::MAG_W:0]       ny;
	logic                           ge_x;
	logic                           ge_y;

	// One restoring step per lane; the first step skips the doubling
	always_comb begin
		tx   = (cnt_q == '0) ? {1'b0, rx_q} : {rx_q, 1'b0};
		ty   = (cnt_q == '0) ? {1'b0, ry_q} : {ry_q, 1'b0};
		ge_x = (tx >= {1'b0, den_q});
		ge_y = (ty >= {1'b0, den_q});
		nx   = ge_x ? (tx - {1'b0, den_q}) : tx;
		ny   = ge_y ? (ty - {1'b0, den_q}) : ty;
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == dlps_pkg::DIV_CNT_W'(dlps_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Remainders and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rx_q       <= req.num_x;
			ry_q       <= req.num_y;
			den_q      <= req.den;
			den_zero_q <= (req.den == '0);
		end else if (busy_q) begin
			rx_q <= nx[dlps_pkg::MAG_W-1:0];
			ry_q <= ny[dlps_pkg::MAG_W-1:0];
			qx_q <= {qx_q[dlps_pkg::QUO_W-2:0], ge_x};
			qy_q <= {qy_q[dlps_pkg::QUO_W-2:0], ge_y};
		end
	end

	// Zero-length line gives zero increments
	assign res.done = done_q;
	assign res.q_x  = den_zero_q ? '0 : qx_q;
	assign res.q_y  = den_zero_q ? '0 : qy_q;

endmodule

// ===== hw/rtl/dlps_back.sv =====
module dlps_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dlps_pkg::dlps_cfg_t     cfg,
	input  dlps_pkg::dlps_cmd_t     head,
	input  logic                    empty,
	output logic                    pop,
	output dlps_pkg::dlps_div_req_t div_req,
	input  dlps_pkg::dlps_div_res_t div_res,
	output logic                    point_valid,
	input  logic                    point_stall,
	output dlps_pkg::dlps_out_t     point
);

	localparam logic [dlps_pkg::POS_W-1:0] HALF =
		dlps_pkg::POS_W'(1) << (dlps_pkg::STEP_FRAC_BITS - 1);

	dlps_pkg::dlps_state_t state_q;
	dlps_pkg::dlps_state_t state_d;

	// Line state
	logic signed [dlps_pkg::POS_W-1:0]  pos_x_q;
	logic signed [dlps_pkg::POS_W-1:0]  pos_y_q;
	logic signed [dlps_pkg::STEP_W-1:0] step_x_q;
	logic signed [dlps_pkg::STEP_W-1:0] step_y_q;
	logic [dlps_pkg::PTS_W-1:0]         points_left_q;
	logic                               active_q;
	logic [dlps_pkg::COLOR_W-1:0]       color_q;
	logic                               neg_x_q;
	logic                               neg_y_q;

	// Stage 1: clipped pixel; stage 2: output register with offset
	logic                         valid_s1;
	logic [dlps_pkg::DIM_W-1:0]   px_s1;
	logic [dlps_pkg::DIM_W-1:0]   py_s1;
	logic                         vis_s1;
	logic                         last_s1;
	logic [dlps_pkg::COLOR_W-1:0] color_s1;
	logic                         valid_s2;
	dlps_pkg::dlps_out_t          point_s2;

	logic                                     take_load;
	logic                                     take_step;
	logic                                     s1_free;
	logic                                     s2_free;
	logic [dlps_pkg::MAG_W-1:0]               mag_max;
	logic [dlps_pkg::PTS_W-1:0]               pts;
	logic [dlps_pkg::POS_W-1:0]               lim_x;
	logic [dlps_pkg::POS_W-1:0]               lim_y;
	logic [dlps_pkg::POS_W-1:0]               rnd_x;
	logic [dlps_pkg::POS_W-1:0]               rnd_y;
	logic [dlps_pkg::RND_W-1:0]               rx;
	logic [dlps_pkg::RND_W-1:0]               ry;
	logic                                     vis;
	logic                                     last;
	logic [dlps_pkg::DIM_W+dlps_pkg::LB_W-1:0] row_off;
	logic [dlps_pkg::DIM_W+dlps_pkg::PB_W-1:0] col_off;
	logic [dlps_pkg::STEP_W-1:0]              inc_x;
	logic [dlps_pkg::STEP_W-1:0]              inc_y;

	assign s2_free = !valid_s2 || !point_stall;
	assign s1_free = !valid_s1 || s2_free;

	// Sequencer: take a load into the divider, a step into stage 1, or drop a step with no active line
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		take_load = 1'b0;
		take_step = 1'b0;
		unique case (state_q)
			dlps_pkg::ST_IDLE: begin
				if (!empty) begin
					if (!head.is_step) begin
						pop       = 1'b1;
						take_load = 1'b1;
						state_d   = dlps_pkg::ST_DIV;
					end else if (!active_q) begin
						pop = 1'b1;
					end else if (s1_free) begin
						pop       = 1'b1;
						take_step = 1'b1;
					end
				end
			end
			dlps_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_d = dlps_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load setup: longer axis sets the step count and the divisor
	always_comb begin
		mag_max         = (head.mag_x > head.mag_y) ? head.mag_x : head.mag_y;
		pts             = dlps_pkg::PTS_W'(mag_max[dlps_pkg::MAG_W-1:dlps_pkg::COORD_FRAC_BITS])
		                + 1'b1;
		div_req.start   = take_load;
		div_req.num_x   = head.mag_x;
		div_req.num_y   = head.mag_y;
		div_req.den     = mag_max;
		inc_x           = {1'b0, div_res.q_x};
		inc_y           = {1'b0, div_res.q_y};
	end

	// Clip and round the current position
	always_comb begin
		lim_x = dlps_pkg::POS_W'({cfg.map_width, {dlps_pkg::STEP_FRAC_BITS{1'b0}}});
		lim_y = dlps_pkg::POS_W'({cfg.map_height, {dlps_pkg::STEP_FRAC_BITS{1'b0}}});
		rnd_x = $unsigned(pos_x_q) + HALF;
		rnd_y = $unsigned(pos_y_q) + HALF;
		rx    = rnd_x[dlps_pkg::STEP_FRAC_BITS +: dlps_pkg::RND_W];
		ry    = rnd_y[dlps_pkg::STEP_FRAC_BITS +: dlps_pkg::RND_W];
		vis   = !pos_x_q[dlps_pkg::POS_W-1] && ($unsigned(pos_x_q) < lim_x)
		     && !pos_y_q[dlps_pkg::POS_W-1] && ($unsigned(pos_y_q) < lim_y)
		     && (rx < {1'b0, cfg.image_width}) && (ry < {1'b0, cfg.image_height});
		last  = (points_left_q <= dlps_pkg::PTS_W'(1));
	end

	// Control part of the line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			points_left_q <= '0;
		end else if (take_load) begin
			active_q      <= 1'b1;
			points_left_q <= pts;
		end else if (take_step) begin
			if (last) begin
				active_q      <= 1'b0;
				points_left_q <= '0;
			end else begin
				points_left_q <= points_left_q - 1'b1;
			end
		end
	end

	// Position, increments and color
	always_ff @(posedge clk) begin
		if (take_load) begin
			pos_x_q <= head.pos_x;
			pos_y_q <= head.pos_y;
			color_q <= head.color;
			neg_x_q <= head.neg_x;
			neg_y_q <= head.neg_y;
		end else if (take_step) begin
			pos_x_q <= pos_x_q
			         + {{(dlps_pkg::POS_W-dlps_pkg::STEP_W){step_x_q[dlps_pkg::STEP_W-1]}},
			            step_x_q};
			pos_y_q <= pos_y_q
			         + {{(dlps_pkg::POS_W-dlps_pkg::STEP_W){step_y_q[dlps_pkg::STEP_W-1]}},
			            step_y_q};
		end
		if (div_res.done) begin
			step_x_q <= neg_x_q ? (dlps_pkg::STEP_W'(0) - inc_x) : inc_x;
			step_y_q <= neg_y_q ? (dlps_pkg::STEP_W'(0) - inc_y) : inc_y;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= take_step;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Byte offset of the clipped pixel
	always_comb begin
		row_off = py_s1 * cfg.line_bytes;
		col_off = px_s1 * cfg.pixel_bytes;
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (take_step) begin
			px_s1    <= vis ? rx[dlps_pkg::DIM_W-1:0] : '0;
			py_s1    <= vis ? ry[dlps_pkg::DIM_W-1:0] : '0;
			vis_s1   <= vis;
			last_s1  <= last;
			color_s1 <= color_q;
		end
		if (s2_free && valid_s1) begin
			point_s2.pixel_x     <= px_s1;
			point_s2.pixel_y     <= py_s1;
			point_s2.byte_offset <= dlps_pkg::OFF_W'(row_off) + dlps_pkg::OFF_W'(col_off);
			point_s2.pixel_color <= color_s1;
			point_s2.visible     <= vis_s1;
			point_s2.last_point  <= last_s1;
		end
	end

	assign point_valid = valid_s2;
	assign point       = point_s2;

endmodule

// ===== dv/dda_line_pixel_stepper_unit_tb.sv =====
`timescale 1ns / 100ps

module dda_line_pixel_stepper_unit_tb;
	import dlps_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int PHASES        = 6;
	localparam int MAX_PRINTS    = 200;
	localparam int GAP_PCT       = 28;
	localparam int PX            = 1 << COORD_FRAC_BITS;
	localparam int COORD_MIN     = -(1 << (COORD_W - 1));
	localparam int COORD_MAX     = (1 << (COORD_W - 1)) - 1;

	// indexes past the register file, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);

	typedef struct {
		dlps_in_t  beat;
		bit        typed;
		dlps_out_t point;
	} stim_row_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  item_valid  = 1'b0;
	logic                  item_stall;
	dlps_in_t              item        = '0;
	logic                  point_valid;
	logic                  point_stall = 1'b0;
	dlps_out_t             point;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// line stepper shadow state
	dlps_cfg_t                regs_shadow;
	logic signed [POS_W-1:0]  cur_x, cur_y;
	logic signed [STEP_W-1:0] inc_x, inc_y;
	logic [PTS_W-1:0]         pts_left;
	bit                       drawing;
	logic [COLOR_W-1:0]       draw_color;

	dlps_out_t  expected_points[$];
	stim_row_t  directed_rows[$];
	bit         row_typed = 1'b0;
	dlps_out_t  row_point = '0;
	bit         gaps_on   = 1'b1;
	int         mismatches  = 0;
	int         cycle_count = 0;

	dda_line_pixel_stepper_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		point_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	function automatic logic signed [STEP_W-1:0] per_step_inc(input longint d,
			input longint span);
		longint mag;
		if (span == 0)
			return '0;
		mag = ((d < 0 ? -d : d) << STEP_FRAC_BITS) / span;
		return STEP_W'(d < 0 ? -mag : mag);
	endfunction

	function automatic logic signed [POS_W-1:0] coord_to_fixed(input longint c);
		return POS_W'((c <<< POS_UP) >>> POS_DN);
	endfunction

	task automatic reset_shadow();
		regs_shadow.map_width    = RST_MAP_WIDTH;
		regs_shadow.map_height   = RST_MAP_HEIGHT;
		regs_shadow.image_width  = RST_IMAGE_WIDTH;
		regs_shadow.image_height = RST_IMAGE_HEIGHT;
		regs_shadow.line_bytes   = RST_LINE_BYTES;
		regs_shadow.pixel_bytes  = RST_PIXEL_BYTES;
		cur_x      = '0;
		cur_y      = '0;
		inc_x      = '0;
		inc_y      = '0;
		pts_left   = '0;
		drawing    = 1'b0;
		draw_color = '0;
	endtask

	task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_MAP_WIDTH:    regs_shadow.map_width    = data[DIM_W-1:0];
			CFG_MAP_HEIGHT:   regs_shadow.map_height   = data[DIM_W-1:0];
			CFG_IMAGE_WIDTH:  regs_shadow.image_width  = data[DIM_W-1:0];
			CFG_IMAGE_HEIGHT: regs_shadow.image_height = data[DIM_W-1:0];
			CFG_LINE_BYTES:   regs_shadow.line_bytes   = data[LB_W-1:0];
			CFG_PIXEL_BYTES:  regs_shadow.pixel_bytes  = data[PB_W-1:0];
			default: ;
		endcase
	endtask

	// next point of the line, or a new line set up on a load beat
	task automatic step_line(input dlps_in_t it, output bit has_pt,
			output dlps_out_t pt);
		longint sx, sy, dx, dy, ax, ay, span;
		longint fx, fy, rx, ry, lim_x, lim_y, half;
		has_pt = 1'b0;
		pt     = '0;
		if (it.mode == MODE_LOAD) begin
			sx   = longint'(signed'(it.start_x));
			sy   = longint'(signed'(it.start_y));
			dx   = longint'(signed'(it.end_x)) - sx;
			dy   = longint'(signed'(it.end_y)) - sy;
			ax   = dx < 0 ? -dx : dx;
			ay   = dy < 0 ? -dy : dy;
			span = ax > ay ? ax : ay;
			cur_x      = coord_to_fixed(sx);
			cur_y      = coord_to_fixed(sy);
			inc_x      = per_step_inc(dx, span);
			inc_y      = per_step_inc(dy, span);
			pts_left   = PTS_W'((span >> COORD_FRAC_BITS) + 1);
			draw_color = it.color;
			drawing    = 1'b1;
		end else if (drawing) begin
			fx    = cur_x;
			fy    = cur_y;
			lim_x = longint'(regs_shadow.map_width) << STEP_FRAC_BITS;
			lim_y = longint'(regs_shadow.map_height) << STEP_FRAC_BITS;
			half  = longint'(1) << (STEP_FRAC_BITS - 1);
			// clip on the raw position, then on the rounded pixel
			if (fx >= 0 && fx < lim_x && fy >= 0 && fy < lim_y) begin
				rx = (fx + half) >>> STEP_FRAC_BITS;
				ry = (fy + half) >>> STEP_FRAC_BITS;
				if (rx < longint'(regs_shadow.image_width) &&
						ry < longint'(regs_shadow.image_height)) begin
					pt.visible     = 1'b1;
					pt.pixel_x     = DIM_W'(rx);
					pt.pixel_y     = DIM_W'(ry);
					pt.byte_offset = OFF_W'(ry * longint'(regs_shadow.line_bytes) +
						rx * longint'(regs_shadow.pixel_bytes));
				end
			end
			pt.pixel_color = draw_color;
			pt.last_point  = (pts_left <= 1);
			cur_x = cur_x + inc_x;
			cur_y = cur_y + inc_y;
			if (pt.last_point) begin
				pts_left = '0;
				drawing  = 1'b0;
			end else begin
				pts_left = pts_left - 1'b1;
			end
			has_pt = 1'b1;
		end
	endtask

	task automatic check_point(input dlps_out_t got, input dlps_out_t want);
		if (got.pixel_x !== want.pixel_x)
			report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
		if (got.pixel_y !== want.pixel_y)
			report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
		if (got.byte_offset !== want.byte_offset)
			report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
		if (got.pixel_color !== want.pixel_color)
			report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
		if (got.visible !== want.visible)
			report_mismatch("visible", got.visible, want.visible);
		if (got.last_point !== want.last_point)
			report_mismatch("last_point", got.last_point, want.last_point);
	endtask

	// beat monitor: predict on item beats, check on point beats
	always @(posedge clk) begin : beat_monitor
		bit        has_pt;
		dlps_out_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				step_line(item, has_pt, want);
				if (row_typed) begin
					if (has_pt)
						want = row_point;
					else
						report_mismatch("typed row gives no point", 0, 1);
				end
				if (has_pt)
					expected_points.push_back(want);
			end
			if (point_valid && !point_stall) begin
				if (expected_points.size() == 0) begin
					report_mismatch("unexpected point", 64'(point), 0);
				end else begin
					want = expected_points.pop_front();
					check_point(point, want);
				end
			end
		end
	end

	function automatic int clamp_coord(input longint v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return int'(v);
	endfunction

	function automatic dlps_in_t load_beat(input int sx, input int sy, input int ex,
			input int ey, input logic [COLOR_W-1:0] color);
		dlps_in_t b;
		b.mode    = MODE_LOAD;
		b.start_x = COORD_W'(sx);
		b.start_y = COORD_W'(sy);
		b.end_x   = COORD_W'(ex);
		b.end_y   = COORD_W'(ey);
		b.color   = color;
		return b;
	endfunction

	// coordinates of a step beat are don't-care, fill them with noise
	function automatic dlps_in_t step_beat();
		dlps_in_t b;
		b      = load_beat($urandom, $urandom, $urandom, $urandom, $urandom);
		b.mode = MODE_STEP;
		return b;
	endfunction

	function automatic dlps_out_t point_rec(input int px, input int py, input int off,
			input logic [COLOR_W-1:0] color, input bit vis, input bit last);
		dlps_out_t p;
		p.pixel_x     = DIM_W'(px);
		p.pixel_y     = DIM_W'(py);
		p.byte_offset = OFF_W'(off);
		p.pixel_color = color;
		p.visible     = vis;
		p.last_point  = last;
		return p;
	endfunction

	// start somewhere around the map, a few pixels over each edge
	function automatic int pick_coord(input int dim_px);
		longint v;
		v = longint'($urandom_range(0, (dim_px + 16) << COORD_FRAC_BITS)) -
			(longint'(8) << COORD_FRAC_BITS);
		return clamp_coord(v);
	endfunction

	function automatic int offset_coord(input int c);
		longint d;
		if ($urandom_range(9) == 0)
			return c;
		d = $urandom_range(0, 40 << COORD_FRAC_BITS);
		return clamp_coord($urandom_range(1) ? c + d : c - d);
	endfunction

	task automatic add_row(input dlps_in_t b, input bit typed, input dlps_out_t p);
		stim_row_t r;
		r.beat  = b;
		r.typed = typed;
		r.point = p;
		directed_rows.push_back(r);
	endtask

	// tasks below start and end on a falling edge
	task automatic send_item(input dlps_in_t b, input bit typed, input dlps_out_t p);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= b;
		item_valid <= 1'b1;
		row_typed   = typed;
		row_point   = p;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_write(idx, data);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] mw, mh, iw, ih, lb, pb);
		write_reg(CFG_MAP_WIDTH, mw);
		write_reg(CFG_MAP_HEIGHT, mh);
		write_reg(CFG_IMAGE_WIDTH, iw);
		write_reg(CFG_IMAGE_HEIGHT, ih);
		write_reg(CFG_LINE_BYTES, lb);
		write_reg(CFG_PIXEL_BYTES, pb);
	endtask

	// drain points, then give a pending load time to leave the divider
	task automatic wait_idle();
		item_valid <= 1'b0;
		cfg_valid  <= 1'b0;
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int items);
		int        sent, n, k, r, i;
		int        sx, sy, ex, ey;
		longint    ax, ay;
		dlps_out_t no_point;
		no_point = '0;
		sent     = 0;
		while (sent < items) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// stray step, maybe past the end of a line
				send_item(step_beat(), 1'b0, no_point);
			end else if (r < 18) begin
				// full-range coordinates, cut short by the next load
				send_item(load_beat($urandom, $urandom, $urandom, $urandom, $urandom),
					1'b0, no_point);
				k = $urandom_range(1, 4);
				for (i = 0; i < k; i++)
					send_item(step_beat(), 1'b0, no_point);
				sent += 1 + k;
			end else begin
				sx = pick_coord(regs_shadow.map_width);
				sy = pick_coord(regs_shadow.map_height);
				if ($urandom_range(19) == 0) begin
					ex = sx;
					ey = sy;
				end else begin
					ex = offset_coord(sx);
					ey = offset_coord(sy);
				end
				ax = ex > sx ? ex - sx : sx - ex;
				ay = ey > sy ? ey - sy : sy - ey;
				n  = int'(((ax > ay ? ax : ay) >> COORD_FRAC_BITS) + 1);
				r  = $urandom_range(99);
				if (r < 85)
					k = n;
				else if (r < 92)
					k = n + $urandom_range(1, 2);
				else
					k = $urandom_range(0, n - 1);
				send_item(load_beat(sx, sy, ex, ey, $urandom), 1'b0, no_point);
				for (i = 0; i < k; i++)
					send_item(step_beat(), 1'b0, no_point);
				sent += 1 + (k < n ? k : n);
			end
		end
	endtask

	initial begin : stimulus
		dlps_out_t no_point;
		int        phase_idx;
		no_point = '0;
		reset_shadow();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows under reset register values
		add_row(step_beat(), 1'b0, no_point);
		// zero length line: one point at the start, then nothing
		add_row(load_beat(0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, no_point);
		add_row(step_beat(), 1'b1, point_rec(0, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b1));
		add_row(step_beat(), 1'b0, no_point);
		// exact unit steps along a row
		add_row(load_beat(10 * PX, 20 * PX, 13 * PX, 20 * PX, 32'h1234_5678), 1'b0, no_point);
		add_row(step_beat(), 1'b1, point_rec(10, 20, 81960, 32'h1234_5678, 1'b1, 1'b0));
		add_row(step_beat(), 1'b1, point_rec(11, 20, 81964, 32'h1234_5678, 1'b1, 1'b0));
		add_row(step_beat(), 1'b1, point_rec(12, 20, 81968, 32'h1234_5678, 1'b1, 1'b0));
		add_row(step_beat(), 1'b1, point_rec(13, 20, 81972, 32'h1234_5678, 1'b1, 1'b1));
		// diagonal entering the map from negative coordinates
		add_row(load_beat(-2 * PX, -2 * PX, 2 * PX, 2 * PX, 32'h00FF_00FF), 1'b0, no_point);
		repeat (5) add_row(step_beat(), 1'b0, no_point);
		// coordinate extremes, off the map, replaced mid-line
		add_row(load_beat(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 32'h0), 1'b0, no_point);
		repeat (2) add_row(step_beat(), 1'b1, point_rec(0, 0, 0, 32'h0, 1'b0, 1'b0));
		// half-pixel start rounds away from zero
		add_row(load_beat(PX / 2, 383, PX / 2 + 2 * PX, 383, 32'hA5A5_0F0F), 1'b0, no_point);
		repeat (3) add_row(step_beat(), 1'b0, no_point);

		foreach (directed_rows[i])
			send_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].point);
		row_typed = 1'b0;
		wait_idle();

		// random lines across register settings
		for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
			case (phase_idx)
				0: set_config('1, '1, '1, '1, '1, '1);
				1: set_config('0, '0, '0, '0, '0, '0);
				2: set_config(40, 30, 32, 24, 128, 4);
				3: begin
					set_config(24, 20, 64, 64, 256, 3);
					write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
					write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
				end
				4: set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
				default: set_config(1024, 768, 1024, 768, 4096, 8);
			endcase
			cfg_valid <= 1'b0;
			// one long stretch with both sides running flat out
			gaps_on = (phase_idx != 2);
			run_phase(RANDOM_ITEMS / PHASES);
			wait_idle();
		end

		if (expected_points.size() != 0)
			report_mismatch("points never seen", expected_points.size(), 0);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
